// File: src/staleness_poll_scheduler_macros.svh
// assertion macros shared by the poll scheduler modules
// depends on nothing; included by the files that carry assertions
`ifndef STALENESS_POLL_SCHEDULER_MACROS_SVH
`define STALENESS_POLL_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPS_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poll scheduler check failed");

// next-cycle implication, checked out of reset
`define SPS_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poll scheduler check failed");

`endif

// File: src/spsch_pkg.sv
// types, codes and the microcode program of the poll scheduler
// no dependencies; used by the sequencer and the top level
package spsch_pkg;

    // number of slave nodes on the bus
    localparam int NODE_COUNT = 16;

    // item commands
    localparam logic [1:0] CMD_RECORD   = 2'd0;
    localparam logic [1:0] CMD_AVAIL    = 2'd1;
    localparam logic [1:0] CMD_POLL     = 2'd2;
    localparam logic [1:0] CMD_DISCOVER = 2'd3;

    // reply and request kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_SETTINGS = 2'd1;
    localparam logic [1:0] KIND_CELL     = 2'd2;
    localparam logic [1:0] KIND_INFO     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CELL     = 2'd0;
    localparam logic [1:0] REG_SETTINGS = 2'd1;
    localparam logic [1:0] REG_INFO     = 2'd2;
    localparam logic [1:0] REG_GAP      = 2'd3;

    // configuration reset values
    localparam logic [31:0] CELL_INTERVAL_RST     = 32'd5000;
    localparam logic [31:0] SETTINGS_INTERVAL_RST = 32'd10000;
    localparam logic [31:0] INFO_INTERVAL_RST     = 32'd3600000;
    localparam logic [31:0] RESEND_GAP_RST        = 32'd2500;

    typedef logic [3:0] step_t;

    // program steps
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DISPATCH = 4'd1;
    localparam step_t STEP_RECORD   = 4'd2;
    localparam step_t STEP_AVAIL    = 4'd3;
    localparam step_t STEP_PSET     = 4'd4;
    localparam step_t STEP_DSET     = 4'd5;
    localparam step_t STEP_WALK     = 4'd6;
    localparam step_t STEP_NONE     = 4'd7;
    localparam step_t STEP_FOUND    = 4'd8;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_START,
        JMP_CMD,
        JMP_WALK
    } jump_t;

    // one control word
    typedef struct packed {
        jump_t jump;
        step_t target;
        logic  load_poll;
        logic  load_scan;
        logic  walk;
        logic  do_record;
        logic  do_avail;
        logic  commit;
        logic  emit;
    } ctrl_t;

    // control store: jump, target, load_poll, load_scan, walk, record, avail, commit, emit
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        unique case (pc)
            STEP_IDLE:     w = '{JMP_START, STEP_DISPATCH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            STEP_DISPATCH: w = '{JMP_CMD,   STEP_RECORD,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            STEP_RECORD:   w = '{JMP_GOTO,  STEP_IDLE,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
            STEP_AVAIL:    w = '{JMP_GOTO,  STEP_IDLE,     1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
            STEP_PSET:     w = '{JMP_GOTO,  STEP_WALK,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            STEP_DSET:     w = '{JMP_GOTO,  STEP_WALK,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            STEP_WALK:     w = '{JMP_WALK,  STEP_FOUND,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            STEP_NONE:     w = '{JMP_GOTO,  STEP_IDLE,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
            STEP_FOUND:    w = '{JMP_GOTO,  STEP_IDLE,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
            default:       w = '{JMP_GOTO,  STEP_IDLE,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        endcase
        return w;
    endfunction

endpackage

// File: src/spsch_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module spsch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/spsch_seq.sv
// microcode sequencer: step counter, control store fetch and jumps
// depends on spsch_pkg and the assertion macro header
`include "staleness_poll_scheduler_macros.svh"

module spsch_seq
    import spsch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] cmd_sel,
    input  logic       hit,
    input  logic       walk_end,
    output ctrl_t      ctrl,
    output logic       busy
);

    step_t pc_reg;
    step_t pc_next;

    assign ctrl = ucode(pc_reg);
    assign busy = (pc_reg != STEP_IDLE);

    // next step selection
    always_comb
    begin
        unique case (ctrl.jump)
            JMP_NEXT:  pc_next = pc_reg + 4'd1;
            JMP_GOTO:  pc_next = ctrl.target;
            JMP_START: pc_next = start ? ctrl.target : pc_reg;
            JMP_CMD:   pc_next = ctrl.target + step_t'(cmd_sel);
            JMP_WALK:
            begin
                if (hit)
                    pc_next = ctrl.target;
                else if (walk_end)
                    pc_next = pc_reg + 4'd1;
                else
                    pc_next = pc_reg;
            end
            default:   pc_next = STEP_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

    `SPS_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
    `SPS_NEXT(a_hit_to_found, clk, rst_n, ctrl.walk && hit, pc_reg == STEP_FOUND)
    `SPS_IMPLIES(a_found_after_hit, clk, rst_n, pc_reg == STEP_FOUND, $past(ctrl.walk && hit))

endmodule

// File: src/staleness_poll_scheduler.sv
// top level of the poll scheduler: item capture, node walk datapath, stamp stores
// depends on spsch_pkg, spsch_ram, spsch_seq and the assertion macro header
//
//  channel   direction  signals                                   handshake
//  item      in         cmd now node reply_kind avail_value       start & !busy
//  result    out        found chosen_node request_kind ignored    done, one cycle
//  config    in         cfg_index cfg_data                        cfg_we
//
// record and set availability pass the dispatch step and then their own step before
// the done strobe. poll walks up to NODE_COUNT nodes and discover up to NODE_COUNT-1:
// the walk reads one node per cycle from the stamp RAMs through a
// two-stage read and age compare pipeline, and stops at the first hit.
// reset clears the stores through per-node valid bits at once; no clearing pass.
// results cannot be held off; busy is low again in the cycle of the done strobe.
`include "staleness_poll_scheduler_macros.svh"

module staleness_poll_scheduler
    import spsch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] now,
    input  logic [7:0]  node,
    input  logic [1:0]  reply_kind,
    input  logic        avail_value,
    output logic        done,
    output logic        found,
    output logic [3:0]  chosen_node,
    output logic [1:0]  request_kind,
    output logic        ignored,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam logic [NW-1:0] LAST_NODE  = NW'(NODE_COUNT - 1);
    localparam logic [NW-1:0] FIRST_NODE = NW'(1);

    function automatic logic [NW-1:0] next_node(input logic [NW-1:0] n);
        return (n == LAST_NODE) ? FIRST_NODE : n + FIRST_NODE;
    endfunction

    ctrl_t ctrl;
    logic  accept;
    logic  hit;
    logic  walk_end;
    logic  issue;

    // captured item
    logic [1:0]  cmd_reg;
    logic [31:0] now_reg;
    logic [7:0]  node_reg;
    logic [1:0]  kind_reg;
    logic        aval_reg;

    // configuration
    logic [31:0] cell_int_reg;
    logic [31:0] set_int_reg;
    logic [31:0] info_int_reg;
    logic [31:0] gap_reg;

    // per-node flags
    logic [NODE_COUNT-1:0] avail_reg;
    logic [NODE_COUNT-1:0] req_vld_reg;
    logic [NODE_COUNT-1:0] set_vld_reg;
    logic [NODE_COUNT-1:0] cell_vld_reg;
    logic [NODE_COUNT-1:0] info_vld_reg;

    // pointers and walk control
    logic [NW-1:0] poll_ptr_reg;
    logic [NW-1:0] scan_ptr_reg;
    logic [NW-1:0] j_reg;
    logic [CW-1:0] cnt_reg;
    logic          v1_reg;
    logic          v2_reg;

    // walk pipeline payload
    logic [NW-1:0] j1_reg;
    logic          a1_reg;
    logic          rv1_reg;
    logic          sv1_reg;
    logic          cv1_reg;
    logic          iv1_reg;
    logic [NW-1:0] j2_reg;
    logic          a2_reg;
    logic          ready2_reg;
    logic          info2_reg;
    logic          set2_reg;
    logic          cell2_reg;
    logic [NW-1:0] hit_node_reg;
    logic [1:0]    hit_kind_reg;

    // results
    logic       done_reg;
    logic       found_reg;
    logic [3:0] chosen_reg;
    logic [1:0] req_kind_reg;
    logic       ignored_reg;

    // stamp RAM ports
    logic [31:0]   req_rdata;
    logic [31:0]   set_rdata;
    logic [31:0]   cell_rdata;
    logic [31:0]   info_rdata;
    logic          req_we;
    logic          set_we;
    logic          cell_we;
    logic          info_we;
    logic [NW-1:0] node_idx;
    logic          node_in_range;
    logic          disc_mode;

    // stage one compare signals
    logic [31:0] req_stamp;
    logic [31:0] set_stamp;
    logic [31:0] cell_stamp;
    logic [31:0] info_stamp;
    logic [31:0] req_age;
    logic [31:0] set_age;
    logic [31:0] cell_age;
    logic [31:0] info_age;
    logic        ready1;
    logic        set_stale1;
    logic        cell_stale1;
    logic        info_stale1;
    logic [1:0]  hit_kind;

    assign accept        = start && !busy;
    assign node_idx      = node_reg[NW-1:0];
    assign node_in_range = (int'(node_reg) < NODE_COUNT);
    assign disc_mode     = (cmd_reg == CMD_DISCOVER);

    spsch_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd_sel  (cmd_reg),
        .hit      (hit),
        .walk_end (walk_end),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            now_reg  <= now;
            node_reg <= node;
            kind_reg <= reply_kind;
            aval_reg <= avail_value;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_int_reg <= CELL_INTERVAL_RST;
            set_int_reg  <= SETTINGS_INTERVAL_RST;
            info_int_reg <= INFO_INTERVAL_RST;
            gap_reg      <= RESEND_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL:     cell_int_reg <= cfg_data;
                REG_SETTINGS: set_int_reg  <= cfg_data;
                REG_INFO:     info_int_reg <= cfg_data;
                REG_GAP:      gap_reg      <= cfg_data;
                default:      gap_reg      <= gap_reg;
            endcase
        end
    end

    // stamp store writes
    assign req_we  = ctrl.commit;
    assign set_we  = ctrl.do_record && node_in_range && (kind_reg == KIND_SETTINGS);
    assign cell_we = ctrl.do_record && node_in_range && (kind_reg == KIND_CELL);
    assign info_we = ctrl.do_record && node_in_range && (kind_reg == KIND_INFO);

    spsch_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_req_ram (
        .clk   (clk),
        .we    (req_we),
        .waddr (hit_node_reg),
        .wdata (now_reg),
        .raddr (j_reg),
        .rdata (req_rdata)
    );

    spsch_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (node_idx),
        .wdata (now_reg),
        .raddr (j_reg),
        .rdata (set_rdata)
    );

    spsch_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (node_idx),
        .wdata (now_reg),
        .raddr (j_reg),
        .rdata (cell_rdata)
    );

    spsch_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (node_idx),
        .wdata (now_reg),
        .raddr (j_reg),
        .rdata (info_rdata)
    );

    // valid bits, availability flags and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg    <= '0;
            req_vld_reg  <= '0;
            set_vld_reg  <= '0;
            cell_vld_reg <= '0;
            info_vld_reg <= '0;
            poll_ptr_reg <= '0;
            scan_ptr_reg <= '0;
        end
        else
        begin
            if (ctrl.do_avail && node_in_range)
                avail_reg[node_idx] <= aval_reg;
            if (set_we)
                set_vld_reg[node_idx] <= 1'b1;
            if (cell_we)
                cell_vld_reg[node_idx] <= 1'b1;
            if (info_we)
                info_vld_reg[node_idx] <= 1'b1;
            if (ctrl.commit)
            begin
                req_vld_reg[hit_node_reg] <= 1'b1;
                if (disc_mode)
                    scan_ptr_reg <= hit_node_reg;
                else
                    poll_ptr_reg <= hit_node_reg;
            end
        end
    end

    // walk issue counter and pipeline valids
    assign issue = ctrl.walk && (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg   <= '0;
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            priority if (ctrl.load_poll)
            begin
                j_reg   <= poll_ptr_reg;
                cnt_reg <= CW'(NODE_COUNT);
            end
            else if (ctrl.load_scan)
            begin
                j_reg   <= next_node(scan_ptr_reg);
                cnt_reg <= CW'(NODE_COUNT - 1);
            end
            else if (issue)
            begin
                j_reg   <= next_node(j_reg);
                cnt_reg <= cnt_reg - CW'(1);
            end
            v1_reg <= issue;
            v2_reg <= ctrl.walk && v1_reg;
        end
    end

    // stage one: age compares on the read stamps; never-written entries read zero
    assign req_stamp  = rv1_reg ? req_rdata  : '0;
    assign set_stamp  = sv1_reg ? set_rdata  : '0;
    assign cell_stamp = cv1_reg ? cell_rdata : '0;
    assign info_stamp = iv1_reg ? info_rdata : '0;
    assign req_age    = now_reg - req_stamp;
    assign set_age    = now_reg - set_stamp;
    assign cell_age   = now_reg - cell_stamp;
    assign info_age   = now_reg - info_stamp;

    assign ready1      = a1_reg && (req_age > gap_reg);
    assign set_stale1  = (set_stamp == '0) || (set_age > set_int_reg);
    assign cell_stale1 = (cell_stamp == '0) || (cell_age > cell_int_reg);
    assign info_stale1 = (info_stamp == '0) || (info_age > info_int_reg);

    // pipeline payload
    always_ff @(posedge clk)
    begin
        j1_reg     <= j_reg;
        a1_reg     <= avail_reg[j_reg];
        rv1_reg    <= req_vld_reg[j_reg];
        sv1_reg    <= set_vld_reg[j_reg];
        cv1_reg    <= cell_vld_reg[j_reg];
        iv1_reg    <= info_vld_reg[j_reg];
        j2_reg     <= j1_reg;
        a2_reg     <= a1_reg;
        ready2_reg <= ready1;
        info2_reg  <= info_stale1;
        set2_reg   <= set_stale1;
        cell2_reg  <= cell_stale1;
    end

    // stage two: hit decision; poll priority device info, settings, cell info; discover hits unavailable nodes
    always_comb
    begin
        if (disc_mode)
        begin
            hit      = v2_reg && !a2_reg;
            hit_kind = KIND_CELL;
        end
        else
        begin
            hit = v2_reg && ready2_reg && (info2_reg || set2_reg || cell2_reg);
            priority if (info2_reg)
                hit_kind = KIND_INFO;
            else if (set2_reg)
                hit_kind = KIND_SETTINGS;
            else
                hit_kind = KIND_CELL;
        end
    end

    assign walk_end = (cnt_reg == '0) && !v1_reg && !v2_reg;

    // hold the first hit for the commit step
    always_ff @(posedge clk)
    begin
        if (ctrl.walk && hit)
        begin
            hit_node_reg <= j2_reg;
            hit_kind_reg <= hit_kind;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            chosen_reg   <= '0;
            req_kind_reg <= KIND_NONE;
            ignored_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            if (ctrl.emit)
            begin
                found_reg    <= ctrl.commit;
                chosen_reg   <= ctrl.commit ? 4'(hit_node_reg) : 4'd0;
                req_kind_reg <= ctrl.commit ? hit_kind_reg : KIND_NONE;
                ignored_reg  <= (ctrl.do_record || ctrl.do_avail) && !node_in_range;
            end
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign chosen_node  = chosen_reg;
    assign request_kind = req_kind_reg;
    assign ignored      = ignored_reg;

    `SPS_IMPLIES(a_found_has_kind, clk, rst_n, done && found, request_kind != KIND_NONE)
    `SPS_IMPLIES(a_miss_no_node, clk, rst_n, done && !found, chosen_node == 4'd0)
    `SPS_IMPLIES(a_miss_no_kind, clk, rst_n, done && !found, request_kind == KIND_NONE)
    `SPS_IMPLIES(a_ignored_not_found, clk, rst_n, done && ignored, !found)

endmodule
